// File: src/tcu_pkg.sv
// Package: payload types, register offsets and masks for the timer counter unit.
`timescale 1ns / 1ps
package tcu_pkg;

    localparam int MaxTimers = 8;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_IDLE  = 2'd3;

    localparam logic [7:0] A_EN     = 8'h10;
    localparam logic [7:0] A_EN_SET = 8'h14;
    localparam logic [7:0] A_EN_CLR = 8'h18;
    localparam logic [7:0] A_STOP   = 8'h1c;
    localparam logic [7:0] A_FLAG   = 8'h20;
    localparam logic [7:0] A_FL_SET = 8'h24;
    localparam logic [7:0] A_FL_CLR = 8'h28;
    localparam logic [7:0] A_ST_SET = 8'h2c;
    localparam logic [7:0] A_MASK   = 8'h30;
    localparam logic [7:0] A_MK_SET = 8'h34;
    localparam logic [7:0] A_MK_CLR = 8'h38;
    localparam logic [7:0] A_ST_CLR = 8'h3c;
    localparam logic [7:0] A_TWIN   = 8'h40;
    localparam logic [7:0] A_SCMP   = 8'he0;
    localparam logic [7:0] A_SCNT   = 8'he8;
    localparam logic [7:0] A_SCTL   = 8'hec;
    localparam logic [7:0] A_STAT   = 8'hf0;
    localparam logic [7:0] A_SS_SET = 8'hf4;
    localparam logic [7:0] A_SS_CLR = 8'hf8;

    localparam logic [3:0] OFF_FULL = 4'h0;
    localparam logic [3:0] OFF_HALF = 4'h4;
    localparam logic [3:0] OFF_CNT  = 4'h8;
    localparam logic [3:0] OFF_CTL  = 4'hc;

    localparam logic [15:0] EN_MASK     = 16'h803f;
    localparam logic [21:0] FLAG_MASK   = 22'h3f803f;
    localparam logic [16:0] STOP_MASK   = 17'h1803f;
    localparam logic [18:0] STAT_MASK   = 19'h60006;
    localparam logic [15:0] SYSCTL_MASK = 16'h823f;
    localparam logic [9:0]  TCTL_MASK   = 10'h3bf;
    localparam int          SYS_BIT     = 15;

    localparam logic [23:0] IRQ0_M0 = 24'h008000;
    localparam logic [23:0] IRQ1_M0 = 24'h200020;
    localparam logic [23:0] IRQ2_M0 = 24'h1f001f;
    localparam logic [23:0] IRQ0_M1 = 24'h010001;
    localparam logic [23:0] IRQ1_M1 = 24'h020002;
    localparam logic [23:0] IRQ2_M1 = 24'hfc00fc;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  addr;
        logic [31:0] wdata;
        logic [2:0]  source_edges;
    } tcu_in_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq_line0;
        logic        irq_line1;
        logic        irq_line2;
        logic        bad_address;
    } tcu_out_t;

    // Decoded beat handed from the front to the back.
    typedef struct packed {
        logic        tick;
        logic        rd;
        logic        wr;
        logic        twin;
        logic [2:0]  tsel;
        logic [3:0]  off;
        logic [7:0]  addr;
        logic [31:0] wdata;
        logic [2:0]  edges;
    } tcu_op_t;

    // Prescaler step: returns fire flag in bit 10, new count below.
    function automatic logic [10:0] presc_step(input logic [9:0] cnt,
                                               input logic [5:0] ctl,
                                               input logic [2:0] edges);
        logic [2:0]  sel;
        logic        have;
        logic [9:0]  nc;
        logic [10:0] lim;
        sel  = ctl[5:3];
        have = ctl[2] ? edges[2] : ctl[1] ? edges[1] : ctl[0] ? edges[0] : 1'b0;
        nc   = cnt + 10'd1;
        lim  = 11'd1 << {sel, 1'b0};
        if (sel > 3'd5 || !have) begin
            presc_step = {1'b0, cnt};
        end else if ({1'b0, nc} >= lim || nc == 10'd0) begin
            presc_step = {1'b1, 10'd0};
        end else begin
            presc_step = {1'b0, nc};
        end
    endfunction

endpackage

// File: src/timer_counter_unit_regs.sv
// Top level: timer counter unit with compare behind a beat-based register bus.
`timescale 1ns / 1ps
//
//  channel  | direction | payload              | handshake
//  ---------+-----------+----------------------+----------------------
//  s_       | in        | cmd/addr/wdata/edges | s_valid / s_ready
//  m_       | out       | rdata/irq/bad        | m_valid / m_ready
//  cfg_     | in        | irq_map_mode         | cfg_valid / cfg_ready
//
// One beat per clock sustained while m_ready stays high; each beat's result
// passes through the decode queue, then the state update and result
// register. The state of all timers is updated together.
// Reset is synchronous on aresetn low and clears all timer state.
// A stalled m_ready fills the two-entry decode queue before s_ready drops.
module timer_counter_unit_regs #(
    parameter int NUM_TIMERS = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tcu_pkg::tcu_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tcu_pkg::tcu_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import tcu_pkg::*;

    tcu_op_t q_data;
    logic    q_valid, q_ready;
    logic    map_reg;

    // Configuration is always accepted; hold the mapping bit.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= 1'b0;
        end else if (cfg_valid) begin
            map_reg <= cfg_data;
        end
    end

    tcu_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    tcu_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .irq_map_mode(map_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// File: src/tcu_front.sv
// Front end: accept input beats, decode them and push into a short queue.
`timescale 1ns / 1ps
module tcu_front #(
    parameter int NUM_TIMERS = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tcu_pkg::tcu_in_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output tcu_pkg::tcu_op_t q_data
);
    import tcu_pkg::*;

    localparam int Depth = 2;

    tcu_op_t     fifo_reg [Depth];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    tcu_op_t     dec;
    logic [8:0]  rel;
    logic        push, pop;

    always_comb begin
        rel       = {1'b0, s_data.addr} - {1'b0, A_TWIN};
        dec.tick  = (s_data.cmd == CMD_TICK);
        dec.rd    = (s_data.cmd == CMD_READ);
        dec.wr    = (s_data.cmd == CMD_WRITE);
        dec.twin  = !rel[8] && (rel[7:4] < 4'(NUM_TIMERS));
        dec.tsel  = rel[6:4];
        dec.off   = s_data.addr[3:0];
        dec.addr  = s_data.addr;
        dec.wdata = s_data.wdata;
        dec.edges = s_data.source_edges;
    end

    assign s_ready = (cnt_reg != 2'(Depth));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = fifo_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            fifo_reg[wp_reg] <= dec;
        end
    end
endmodule

// File: src/tcu_back.sv
// Back end: timer state, register file, tick handling and result register.
`timescale 1ns / 1ps
module tcu_back #(
    parameter int NUM_TIMERS = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              irq_map_mode,
    input  logic              q_valid,
    output logic              q_ready,
    input  tcu_pkg::tcu_op_t  q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tcu_pkg::tcu_out_t m_data
);
    import tcu_pkg::*;

    localparam int TW = $clog2(NUM_TIMERS + 1);

    logic [15:0] full_reg [NUM_TIMERS], full_next [NUM_TIMERS];
    logic [15:0] half_reg [NUM_TIMERS], half_next [NUM_TIMERS];
    logic [15:0] tcnt_reg [NUM_TIMERS], tcnt_next [NUM_TIMERS];
    logic [9:0]  tctl_reg [NUM_TIMERS], tctl_next [NUM_TIMERS];
    logic [9:0]  pre_reg [NUM_TIMERS+1], pre_next [NUM_TIMERS+1];
    logic [15:0] en_reg, en_next;
    logic [21:0] flag_reg, flag_next;
    logic [21:0] mask_reg, mask_next;
    logic [16:0] stop_reg, stop_next;
    logic [18:0] stat_reg, stat_next;
    logic [31:0] scmp_reg, scmp_next, stop32_reg, stop32_next;
    logic [31:0] scnt_reg, scnt_next;
    logic [15:0] sctl_reg, sctl_next;
    logic        ov_reg;
    tcu_out_t    out_reg, res;
    logic        go;

    assign q_ready = !ov_reg || m_ready;
    assign go      = q_valid && q_ready;
    assign m_valid = ov_reg;
    assign m_data  = out_reg;

    always_comb begin
        logic [10:0] ps;
        logic [15:0] newen, chg;
        logic [31:0] rd;
        logic        bad;
        logic [TW-1:0] t;
        logic [23:0] irq;
        full_next = full_reg;  half_next = half_reg;
        tcnt_next = tcnt_reg;  tctl_next = tctl_reg;
        pre_next  = pre_reg;   en_next   = en_reg;
        flag_next = flag_reg;  mask_next = mask_reg;
        stop_next = stop_reg;  stat_next = stat_reg;
        scmp_next = scmp_reg;  stop32_next = stop32_reg;
        scnt_next = scnt_reg;  sctl_next = sctl_reg;
        rd = 32'd0; bad = 1'b0; newen = en_reg; chg = 16'd0; ps = 11'd0;
        t = TW'(q_data.tsel);
        if (q_data.tick) begin
            // Advance every enabled timer with a nonzero full value in parallel.
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (en_reg[i] && full_reg[i] != 16'd0) begin
                    ps = presc_step(pre_reg[i], tctl_reg[i][5:0], q_data.edges);
                    pre_next[i] = ps[9:0];
                    if (ps[10]) begin
                        tcnt_next[i] = (tcnt_reg[i] == full_reg[i]) ? 16'd0
                                     : tcnt_reg[i] + 16'd1;
                        if (half_reg[i] == tcnt_next[i]) flag_next[16+i] = 1'b1;
                        if (full_reg[i] == tcnt_next[i]) flag_next[i] = 1'b1;
                    end
                end
            end
            if (en_reg[SYS_BIT] && stop32_reg != 32'd0) begin
                ps = presc_step(pre_reg[NUM_TIMERS], sctl_reg[5:0], q_data.edges);
                pre_next[NUM_TIMERS] = ps[9:0];
                if (ps[10]) begin
                    scnt_next = (scnt_reg == stop32_reg) ? 32'd0 : scnt_reg + 32'd1;
                    if (scmp_reg == scnt_next || stop32_reg == scnt_next)
                        flag_next[SYS_BIT] = 1'b1;
                end
            end
        end else if (q_data.twin && (q_data.rd || q_data.wr)) begin
            if (q_data.wr) begin
                unique case (q_data.off)
                    OFF_FULL: full_next[t] = q_data.wdata[15:0];
                    OFF_HALF: half_next[t] = q_data.wdata[15:0];
                    OFF_CNT:  tcnt_next[t] = q_data.wdata[15:0];
                    OFF_CTL: begin
                        if ((tctl_reg[t][5:0] ^ q_data.wdata[5:0]) != 6'd0)
                            pre_next[t] = 10'd0;
                        tctl_next[t] = q_data.wdata[9:0] & TCTL_MASK;
                        if (q_data.wdata[10]) tcnt_next[t] = 16'd0;
                    end
                    default: bad = 1'b1;
                endcase
                if (half_next[t] == tcnt_next[t]) flag_next[16+t] = 1'b1;
                if (full_next[t] == tcnt_next[t]) flag_next[t] = 1'b1;
            end else begin
                unique case (q_data.off)
                    OFF_FULL: rd = {16'd0, full_reg[t]};
                    OFF_HALF: rd = {16'd0, half_reg[t]};
                    OFF_CNT: begin
                        rd = {16'd0, tcnt_reg[t]};
                        if (half_reg[t] == tcnt_reg[t]) flag_next[16+t] = 1'b1;
                        if (full_reg[t] == tcnt_reg[t]) flag_next[t] = 1'b1;
                    end
                    OFF_CTL: rd = {22'd0, tctl_reg[t]};
                    default: bad = 1'b1;
                endcase
            end
        end else if (q_data.wr) begin
            unique case (q_data.addr)
                A_EN_SET: newen = en_reg | (q_data.wdata[15:0] & EN_MASK);
                A_EN_CLR: newen = en_reg & ~q_data.wdata[15:0] & EN_MASK;
                A_FL_SET: flag_next = flag_reg | (q_data.wdata[21:0] & FLAG_MASK);
                A_FL_CLR: flag_next = flag_reg & ~q_data.wdata[21:0] & FLAG_MASK;
                A_ST_SET: stop_next = stop_reg | (q_data.wdata[16:0] & STOP_MASK);
                A_ST_CLR: stop_next = stop_reg & ~q_data.wdata[16:0] & STOP_MASK;
                A_MK_SET: mask_next = mask_reg | (q_data.wdata[21:0] & FLAG_MASK);
                A_MK_CLR: mask_next = mask_reg & ~q_data.wdata[21:0] & FLAG_MASK;
                A_SCMP: begin
                    scmp_next = q_data.wdata;
                    if (!sctl_reg[15]) stop32_next = q_data.wdata;
                end
                A_SCNT: scnt_next = q_data.wdata;
                A_SCTL: begin
                    if ((sctl_reg[5:0] ^ q_data.wdata[5:0]) != 6'd0)
                        pre_next[NUM_TIMERS] = 10'd0;
                    sctl_next   = q_data.wdata[15:0] & SYSCTL_MASK;
                    stop32_next = q_data.wdata[15] ? 32'hffff_ffff : scmp_reg;
                end
                A_SS_SET: stat_next = stat_reg | (q_data.wdata[18:0] & STAT_MASK);
                A_SS_CLR: stat_next = stat_reg & ~q_data.wdata[18:0] & STAT_MASK;
                default:  bad = 1'b1;
            endcase
            // Enable change: reset prescaler and recheck matches.
            chg = en_reg ^ newen;
            en_next = newen;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (chg[i]) begin
                    pre_next[i] = 10'd0;
                    if (half_reg[i] == tcnt_reg[i]) flag_next[16+i] = 1'b1;
                    if (full_reg[i] == tcnt_reg[i]) flag_next[i] = 1'b1;
                end
            end
            if (chg[SYS_BIT]) begin
                pre_next[NUM_TIMERS] = 10'd0;
                if (scmp_reg == scnt_reg || stop32_reg == scnt_reg)
                    flag_next[SYS_BIT] = 1'b1;
            end
        end else if (q_data.rd) begin
            unique case (q_data.addr)
                A_EN:     rd = {16'd0, en_reg};
                A_EN_SET, A_EN_CLR: rd = 32'd0;
                A_STOP:   rd = {15'd0, stop_reg};
                A_FLAG:   rd = {10'd0, flag_reg};
                A_MASK:   rd = {10'd0, mask_reg};
                A_SCMP:   rd = scmp_reg;
                A_SCNT: begin
                    rd = scnt_reg;
                    if (scmp_reg == scnt_reg || stop32_reg == scnt_reg)
                        flag_next[SYS_BIT] = 1'b1;
                end
                A_SCTL:   rd = {16'd0, sctl_reg};
                A_STAT:   rd = {13'd0, stat_reg};
                default:  bad = 1'b1;
            endcase
        end
        flag_next = flag_next & FLAG_MASK;
        irq = {2'b00, flag_next & ~mask_next};
        res.rdata       = rd;
        res.bad_address = bad;
        if (!irq_map_mode) begin
            res.irq_line0 = |(irq & IRQ0_M0);
            res.irq_line1 = |(irq & IRQ1_M0);
            res.irq_line2 = |(irq & IRQ2_M0);
        end else begin
            res.irq_line0 = |(irq & IRQ0_M1);
            res.irq_line1 = |(irq & IRQ1_M1);
            res.irq_line2 = |(irq & IRQ2_M1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                full_reg[i] <= '0; half_reg[i] <= '0;
                tcnt_reg[i] <= '0; tctl_reg[i] <= '0;
            end
            for (int i = 0; i <= NUM_TIMERS; i++) pre_reg[i] <= '0;
            en_reg <= '0; flag_reg <= '0; mask_reg <= '0;
            stop_reg <= '0; stat_reg <= '0;
            scmp_reg <= '0; stop32_reg <= '0; scnt_reg <= '0; sctl_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (go) begin
                full_reg <= full_next; half_reg <= half_next;
                tcnt_reg <= tcnt_next; tctl_reg <= tctl_next;
                pre_reg  <= pre_next;  en_reg   <= en_next;
                flag_reg <= flag_next; mask_reg <= mask_next;
                stop_reg <= stop_next; stat_reg <= stat_next;
                scmp_reg <= scmp_next; stop32_reg <= stop32_next;
                scnt_reg <= scnt_next; sctl_reg <= sctl_next;
                ov_reg   <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
        if (go) begin
            out_reg <= res;
        end
    end
endmodule

// File: bench/tb_timer_counter_unit_regs.sv
// Testbench: checks the timer counter unit against a cycle-free predictor of its registers.
`timescale 1ns / 1ps

class tcu_scoreboard;
    tcu_pkg::tcu_out_t pending_results[$];
    int                mismatches;
    int                checked;

    // Timer, system timer and register state of the predictor.
    bit        irq_mode;
    bit [15:0] full_v[6];
    bit [15:0] half_v[6];
    bit [15:0] cnt_v[6];
    bit [9:0]  ctl_v[6];
    bit [9:0]  pre_v[7];
    bit [31:0] en_r, flag_r, mask_r, stop_r, stat_r;
    bit [31:0] scmp, stop_top, scnt, sctl;

    function void clear_state();
        irq_mode = 0;
        foreach (full_v[i]) begin
            full_v[i] = 0; half_v[i] = 0; cnt_v[i] = 0; ctl_v[i] = 0;
        end
        foreach (pre_v[i]) pre_v[i] = 0;
        en_r = 0; flag_r = 0; mask_r = 0; stop_r = 0; stat_r = 0;
        scmp = 0; stop_top = 0; scnt = 0; sctl = 0;
        pending_results.delete();
        mismatches = 0;
        checked = 0;
    endfunction

    function void match_timer(int i);
        bit [31:0] f;
        f = 0;
        if (half_v[i] == cnt_v[i]) f |= 32'h10000 << i;
        if (full_v[i] == cnt_v[i]) f |= 32'h1 << i;
        flag_r = (flag_r | f) & 32'h003f803f;
    endfunction

    function void match_sys();
        if (scmp == scnt || stop_top == scnt) flag_r |= 32'h8000;
    endfunction

    function bit presc_fire(int k, bit [31:0] ctl, bit [2:0] edges);
        bit [2:0] sel;
        bit [2:0] src;
        sel = ctl[5:3];
        if (sel > 5) return 0;
        if (ctl[2]) src = 4;
        else if (ctl[1]) src = 2;
        else if (ctl[0]) src = 1;
        else return 0;
        if ((edges & src) == 0) return 0;
        pre_v[k] = pre_v[k] + 10'd1;
        if (32'(pre_v[k]) >= (32'd1 << (2 * sel)) || pre_v[k] == 0) begin
            pre_v[k] = 0;
            return 1;
        end
        return 0;
    endfunction

    function void set_enables(bit [31:0] nv);
        bit [31:0] chg;
        chg = en_r ^ nv;
        en_r = nv & 32'h803f;
        for (int i = 0; i < 6; i++)
            if (chg[i]) begin
                pre_v[i] = 0;
                match_timer(i);
            end
        if (chg[15]) begin
            pre_v[6] = 0;
            match_sys();
        end
    endfunction

    function void set_mode(bit m);
        irq_mode = m;
    endfunction

    // Advance the predictor by one accepted input beat.
    function void note_input(tcu_pkg::tcu_in_t b);
        tcu_pkg::tcu_out_t r;
        bit [31:0] d, rd, irq;
        bit        bad;
        int        t;
        bit [3:0]  off;
        d = b.wdata; rd = 0; bad = 0;
        if (b.cmd == tcu_pkg::CMD_TICK) begin
            for (int i = 0; i < 6; i++) begin
                if (!en_r[i] || full_v[i] == 0) continue;
                if (presc_fire(i, 32'(ctl_v[i]), b.source_edges)) begin
                    cnt_v[i] = (cnt_v[i] == full_v[i]) ? 16'd0 : cnt_v[i] + 16'd1;
                    match_timer(i);
                end
            end
            if (en_r[15] && stop_top != 0)
                if (presc_fire(6, sctl, b.source_edges)) begin
                    scnt = (scnt == stop_top) ? 32'd0 : scnt + 32'd1;
                    match_sys();
                end
        end else if (b.cmd == tcu_pkg::CMD_READ || b.cmd == tcu_pkg::CMD_WRITE) begin
            if (b.addr >= 8'h40 && b.addr < 8'ha0) begin
                t = (b.addr - 8'h40) >> 4;
                off = b.addr[3:0];
                if (b.cmd == tcu_pkg::CMD_WRITE) begin
                    case (off)
                        tcu_pkg::OFF_FULL: full_v[t] = d[15:0];
                        tcu_pkg::OFF_HALF: half_v[t] = d[15:0];
                        tcu_pkg::OFF_CNT:  cnt_v[t] = d[15:0];
                        tcu_pkg::OFF_CTL: begin
                            if ((32'(ctl_v[t]) ^ d) & 32'h3f) pre_v[t] = 0;
                            ctl_v[t] = d[9:0] & 10'h3bf;
                            if (d[10]) cnt_v[t] = 0;
                        end
                        default: bad = 1;
                    endcase
                    match_timer(t);
                end else begin
                    case (off)
                        tcu_pkg::OFF_FULL: rd = full_v[t];
                        tcu_pkg::OFF_HALF: rd = half_v[t];
                        tcu_pkg::OFF_CNT: begin
                            match_timer(t);
                            rd = cnt_v[t];
                        end
                        tcu_pkg::OFF_CTL: rd = ctl_v[t];
                        default: bad = 1;
                    endcase
                end
            end else if (b.cmd == tcu_pkg::CMD_WRITE) begin
                case (b.addr)
                    tcu_pkg::A_EN_SET: set_enables(en_r | (d & 32'h803f));
                    tcu_pkg::A_EN_CLR: set_enables(en_r & ~d & 32'h803f);
                    tcu_pkg::A_FL_SET: flag_r |= d & 32'h3f803f;
                    tcu_pkg::A_FL_CLR: flag_r &= ~d & 32'h3f803f;
                    tcu_pkg::A_ST_SET: stop_r |= d & 32'h1803f;
                    tcu_pkg::A_ST_CLR: stop_r &= ~d & 32'h1803f;
                    tcu_pkg::A_MK_SET: mask_r |= d & 32'h3f803f;
                    tcu_pkg::A_MK_CLR: mask_r &= ~d & 32'h3f803f;
                    tcu_pkg::A_SCMP: begin
                        scmp = d;
                        if (!sctl[15]) stop_top = d;
                    end
                    tcu_pkg::A_SCNT: scnt = d;
                    tcu_pkg::A_SCTL: begin
                        if ((sctl ^ d) & 32'h3f) pre_v[6] = 0;
                        sctl = d & 32'h823f;
                        stop_top = sctl[15] ? 32'hffffffff : scmp;
                    end
                    tcu_pkg::A_SS_SET: stat_r |= d & 32'h60006;
                    tcu_pkg::A_SS_CLR: stat_r &= ~d & 32'h60006;
                    default: bad = 1;
                endcase
            end else begin
                case (b.addr)
                    tcu_pkg::A_EN:     rd = en_r;
                    tcu_pkg::A_EN_SET, tcu_pkg::A_EN_CLR: rd = 0;
                    tcu_pkg::A_STOP:   rd = stop_r;
                    tcu_pkg::A_FLAG:   rd = flag_r;
                    tcu_pkg::A_MASK:   rd = mask_r;
                    tcu_pkg::A_SCMP:   rd = scmp;
                    tcu_pkg::A_SCNT: begin
                        match_sys();
                        rd = scnt;
                    end
                    tcu_pkg::A_SCTL:   rd = sctl;
                    tcu_pkg::A_STAT:   rd = stat_r;
                    default: bad = 1;
                endcase
            end
        end
        irq = flag_r & ~mask_r;
        r.rdata = rd;
        r.bad_address = bad;
        if (!irq_mode) begin
            r.irq_line0 = (irq & 32'h00008000) != 0;
            r.irq_line1 = (irq & 32'h00200020) != 0;
            r.irq_line2 = (irq & 32'h001f001f) != 0;
        end else begin
            r.irq_line0 = (irq & 32'h00010001) != 0;
            r.irq_line1 = (irq & 32'h00020002) != 0;
            r.irq_line2 = (irq & 32'h00fc00fc) != 0;
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(tcu_pkg::tcu_out_t got);
        tcu_pkg::tcu_out_t want;
        checked++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.rdata !== want.rdata || got.irq_line0 !== want.irq_line0
            || got.irq_line1 !== want.irq_line1 || got.irq_line2 !== want.irq_line2
            || got.bad_address !== want.bad_address) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: rdata %h/%h irq %b%b%b/%b%b%b bad %b/%b",
                         want.rdata, got.rdata,
                         want.irq_line0, want.irq_line1, want.irq_line2,
                         got.irq_line0, got.irq_line1, got.irq_line2,
                         want.bad_address, got.bad_address);
        end
    endfunction
endclass

module tb_timer_counter_unit_regs;
    import tcu_pkg::*;

    localparam int CycleLimit = 400000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tcu_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tcu_out_t m_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    tcu_scoreboard timer_board;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  beats_sent;

    timer_counter_unit_regs #(.NUM_TIMERS(6)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Abort a hung run; the limit is many times the slowest correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_timer_counter_unit_regs: done, errors");
            $finish;
        end
    end

    // Check every result beat at the rising edge where it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) timer_board.check_result(m_data);
    end

    // Drive m_ready on the falling edge; hold it low during a hold-off.
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one input beat: idle at random, then hold valid until taken.
    // Valid stays high after the beat so the next one can follow at once.
    task automatic send_beat(input tcu_in_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        timer_board.note_input(b);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic bus_write(input logic [7:0] a, input logic [31:0] d);
        tcu_in_t b;
        b = '{cmd: CMD_WRITE, addr: a, wdata: d, source_edges: 3'($urandom)};
        send_beat(b);
    endtask

    task automatic bus_read(input logic [7:0] a);
        tcu_in_t b;
        b = '{cmd: CMD_READ, addr: a, wdata: $urandom, source_edges: 3'($urandom)};
        send_beat(b);
    endtask

    task automatic tick(input logic [2:0] e);
        tcu_in_t b;
        b = '{cmd: CMD_TICK, addr: 8'($urandom), wdata: $urandom, source_edges: e};
        send_beat(b);
    endtask

    // Drop input valid, wait for all results, let the pipe drain, then write the mode.
    task automatic write_mode(input bit m);
        s_valid <= 1'b0;
        while (timer_board.pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        timer_board.set_mode(m);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_addr();
        logic [7:0] regs[15];
        int r;
        regs = '{A_EN, A_EN_SET, A_EN_CLR, A_STOP, A_FLAG, A_FL_SET, A_FL_CLR,
                 A_ST_SET, A_MASK, A_MK_SET, A_MK_CLR, A_ST_CLR, A_SCMP, A_SCNT,
                 A_STAT};
        r = $urandom_range(99);
        if (r < 55) return A_TWIN + 8'($urandom_range(5) * 16) + 8'($urandom_range(3) * 4);
        if (r < 85) return regs[$urandom_range(14)];
        if (r < 92) return ($urandom_range(1) != 0) ? A_SCTL : A_SS_CLR;
        return 8'($urandom);
    endfunction

    // Small compare values keep matches and wraps frequent.
    function automatic logic [31:0] pick_data(input logic [7:0] a);
        int r;
        r = $urandom_range(99);
        if (r < 10) return $urandom;
        if (r < 15) return 32'hffffffff;
        if (a >= A_TWIN && a < 8'ha0 && a[3:0] == OFF_CTL)
            return {21'($urandom), 1'($urandom_range(3) == 0), 1'b0,
                    3'($urandom_range(3)), 3'($urandom)} & 32'h7ff;
        if (a == A_SCTL) return {16'h0, 1'($urandom), 9'h0, 3'($urandom_range(2)),
                                 3'($urandom)};
        return 32'($urandom_range(12));
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        logic [7:0] a;
        int         r;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 50) tick(3'($urandom));
            else if (r < 53) begin
                send_beat('{cmd: CMD_IDLE, addr: 8'($urandom), wdata: $urandom,
                            source_edges: 3'($urandom)});
            end else begin
                a = pick_addr();
                if (r < 75) bus_read(a);
                else bus_write(a, pick_data(a));
            end
        end
    endtask

    // Long receiver hold-off so the block fills and stalls its input.
    initial begin
        hold_off = 1'b0;
        wait (beats_sent > 600);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (60) @(negedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        int wait_count;
        timer_board = new();
        timer_board.clear_state();
        cycle_count    = 0;
        beats_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        m_ready   = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, every command, bad addresses, wraps, prescaler.
        write_mode(1'b0);
        bus_write(A_TWIN + OFF_FULL, 32'hffffffff);
        bus_write(A_TWIN + OFF_HALF, 32'h0000_0001);
        bus_write(A_TWIN + OFF_CTL, 32'h0000_0401);
        bus_write(A_EN_SET, 32'hffffffff);
        tick(3'd7);
        tick(3'd1);
        bus_read(A_TWIN + OFF_CNT);
        bus_write(A_TWIN + 8'h10 + OFF_FULL, 32'd2);
        bus_write(A_TWIN + 8'h10 + OFF_CNT, 32'd5);
        bus_write(A_TWIN + 8'h10 + OFF_CTL, 32'h0000_0032);
        tick(3'd2);
        bus_write(A_SCMP, 32'd3);
        bus_write(A_SCTL, 32'h0000_8004);
        bus_write(A_SCNT, 32'hffff_fffe);
        tick(3'd4);
        tick(3'd4);
        bus_read(A_SCNT);
        bus_read(A_FLAG);
        bus_write(A_TWIN + 8'h2, 32'h1234);
        bus_read(A_EN_SET);
        bus_read(8'hff);
        bus_write(A_EN, 32'h1);
        send_beat('{cmd: CMD_IDLE, addr: 8'h00, wdata: 32'h0, source_edges: 3'd0});
        bus_write(A_MK_SET, 32'h0000_8000);
        bus_write(A_SS_SET, 32'hffffffff);
        bus_read(A_STAT);

        write_mode(1'b1);
        random_phase(500, 0, 0);
        write_mode(1'b0);
        random_phase(500, 50, 0);
        write_mode(1'b1);
        random_phase(500, 0, 50);
        write_mode(1'b0);
        random_phase(500, 34, 34);

        s_valid <= 1'b0;
        wait_count = 0;
        while (timer_board.pending_results.size() != 0 && wait_count < 5000) begin
            @(negedge aclk);
            wait_count++;
        end
        repeat (10) @(negedge aclk);
        $display("covered %0d input beats and %0d result beats over both irq layouts,",
                 beats_sent, timer_board.checked);
        $display("with idle and stall phases and one long output hold-off");
        if (timer_board.mismatches == 0 && timer_board.pending_results.size() == 0) begin
            $display("tb_timer_counter_unit_regs: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", timer_board.mismatches,
                     timer_board.pending_results.size());
            $display("tb_timer_counter_unit_regs: done, errors");
        end
        $finish;
    end
endmodule
